// File: rtl/bdc_pkg.sv
// Shared types and constants for the cross-shaped binary dilation block.
// No dependencies; used by bdc_cell and binary_dilation_cross.
package bdc_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field and register widths
    localparam int FRAME_WIDTH_W  = 6;
    localparam int FRAME_HEIGHT_W = 11;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int OUT_ROW_W      = 10;
    localparam int OUT_COL_W      = 5;

    // Widths of the effective-size arithmetic (cover the parameter ranges)
    localparam int WIDTH_CALC_W   = 7;
    localparam int HEIGHT_CALC_W  = 13;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 6'd8;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd8;

    // Broadcast control to every column cell
    typedef struct packed {
        logic accept;   // pixel transfer this cycle
        logic pixel;    // pixel value of that transfer
        logic advance;  // row ends: rotate row stores
        logic clear;    // frame ends: load flush values, clear row stores
        logic shift;    // move flush values one cell toward column 0
    } t_cell_ctl;

endpackage

// File: rtl/bdc_cell.sv
// One column cell: holds the column's bits of the three row stores and one
// flush value that moves down the chain. Depends on bdc_pkg.
module bdc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdc_pkg::t_cell_ctl i_ctl,
    input  logic               i_hit,       // this column is being written
    input  logic               i_in_frame,  // column index < width
    input  logic               i_right_in,  // right neighbor index < width
    input  logic               i_left_in,   // left neighbor index < width
    input  logic               i_left_m,
    input  logic               i_right_m,
    input  logic               i_left_l,
    input  logic               i_right_l,
    input  logic               i_right_f,
    output logic               o_m,
    output logic               o_l,         // lower bit incl. this cycle's write
    output logic               o_v,         // cross value, output row r-1
    output logic               o_f          // flush chain value
);

    logic r_u, r_m, r_l, r_f;
    logic n_u, n_m, n_l, n_f;
    logic l_eff;
    logic f_calc;

    assign l_eff = (i_ctl.accept && i_hit) ? i_ctl.pixel : r_l;

    // normal window: up = upper, mid = middle, down = lower
    // left term stays live one column past the width (width shrunk mid-row)
    assign o_v = (i_in_frame & (r_m | r_u | l_eff | (i_right_in & i_right_m)))
               | (i_left_in & i_left_m);
    // last row: up = middle, mid = lower, down = outside
    assign f_calc = i_in_frame & (l_eff | r_m | i_left_l | (i_right_in & i_right_l));

    always_comb begin
        n_u = r_u;
        n_m = r_m;
        n_l = r_l;
        n_f = r_f;
        if (i_ctl.clear) begin
            n_u = 1'b0;
            n_m = 1'b0;
            n_l = 1'b0;
            n_f = f_calc;
        end else if (i_ctl.advance) begin
            n_u = r_m;
            n_m = l_eff;
            n_l = 1'b0;
        end else if (i_ctl.accept && i_hit) begin
            n_l = i_ctl.pixel;
        end
        if (i_ctl.shift) begin
            n_f = i_right_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u <= 1'b0;
            r_m <= 1'b0;
            r_l <= 1'b0;
            r_f <= 1'b0;
        end else begin
            r_u <= n_u;
            r_m <= n_m;
            r_l <= n_l;
            r_f <= n_f;
        end
    end

    assign o_m = r_m;
    assign o_l = l_eff;
    assign o_f = r_f;

endmodule

// File: rtl/binary_dilation_cross.sv
// Top level: streaming 3x3 cross binary dilation over a chain of column cells.
// Depends on bdc_pkg and bdc_cell.
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  -------------------------------------
//  pixel in  in   i_in_valid / o_in_ready    i_pixel_in
//  result    out  o_out_valid / i_out_ready  o_dilated_pixel, o_out_row, o_out_col,
//                                            o_last_of_run, o_end_of_frame
//  config    in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One pixel per cycle. Rows 1.. give one result per pixel, registered one
// cycle after the transfer. The frame's last pixel is followed by W flush
// cycles (W = effective width) in which the last row's values walk down the
// cell chain to column 0 and out through the output register; input is held
// off meanwhile. Reset is synchronous, clears row stores and counters and
// restores the default sizes. A stalled output stops input only when the
// output register is full.
module binary_dilation_cross #(
    parameter int P_MAX_WIDTH  = bdc_pkg::MAX_WIDTH_DEF,
    parameter int P_MAX_HEIGHT = bdc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config
    input  logic                               i_cfg_we,
    input  logic [bdc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_pixel_in,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_dilated_pixel,
    output logic [bdc_pkg::OUT_ROW_W-1:0]      o_out_row,
    output logic [bdc_pkg::OUT_COL_W-1:0]      o_out_col,
    output logic                               o_last_of_run,
    output logic                               o_end_of_frame
);

    localparam int CW = (P_MAX_WIDTH  > 1) ? $clog2(P_MAX_WIDTH)  : 1;
    localparam int RW = (P_MAX_HEIGHT > 1) ? $clog2(P_MAX_HEIGHT) : 1;
    localparam int WC = bdc_pkg::WIDTH_CALC_W;
    localparam int HC = bdc_pkg::HEIGHT_CALC_W;
    localparam logic [WC-1:0] MAXW = WC'(P_MAX_WIDTH);
    localparam logic [HC-1:0] MAXH = HC'(P_MAX_HEIGHT);

    // controller states
    localparam logic ST_RUN   = 1'b0;   // taking pixels
    localparam logic ST_FLUSH = 1'b1;   // emitting the last row

    // ---------------- configuration ----------------
    logic [bdc_pkg::FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [bdc_pkg::FRAME_HEIGHT_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bdc_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bdc_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdc_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[bdc_pkg::FRAME_WIDTH_W-1:0];
                bdc_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, clamp to the maximum
    logic [WC-1:0] fw_ext, w_eff, w_m1;
    logic [HC-1:0] fh_ext, h_eff, h_m1;

    assign fw_ext = WC'(r_frame_width);
    assign fh_ext = HC'(r_frame_height);
    assign w_eff  = (fw_ext == '0) ? WC'(1) : ((fw_ext > MAXW) ? MAXW : fw_ext);
    assign h_eff  = (fh_ext == '0) ? HC'(1) : ((fh_ext > MAXH) ? MAXH : fh_ext);
    assign w_m1   = w_eff - WC'(1);
    assign h_m1   = h_eff - HC'(1);

    // ---------------- control ----------------
    logic          r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_fcol, n_fcol;     // flush column
    logic [RW-1:0] r_frow, n_frow;     // row being flushed

    logic slot_free, accept, row_end, frame_end, flush_load, flush_last;

    assign slot_free  = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_RUN) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign row_end    = (WC'(r_col) >= w_m1);
    assign frame_end  = row_end && (HC'(r_row) >= h_m1);
    assign flush_load = (r_state == ST_FLUSH) && slot_free;
    assign flush_last = (WC'(r_fcol) == w_m1);

    bdc_pkg::t_cell_ctl cell_ctl;

    assign cell_ctl.accept  = accept;
    assign cell_ctl.pixel   = i_pixel_in;
    assign cell_ctl.advance = accept && row_end && !frame_end;
    assign cell_ctl.clear   = accept && frame_end;
    assign cell_ctl.shift   = flush_load;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_fcol  = r_fcol;
        n_frow  = r_frow;
        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (frame_end) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_fcol  = '0;
                        n_frow  = r_row;
                        n_state = ST_FLUSH;
                    end else if (row_end) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (flush_load) begin
                    n_fcol = r_fcol + CW'(1);
                    if (flush_last) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_col   <= '0;
            r_row   <= '0;
            r_fcol  <= '0;
            r_frow  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fcol  <= n_fcol;
            r_frow  <= n_frow;
        end
    end

    // ---------------- cell chain ----------------
    logic [P_MAX_WIDTH-1:0] m_bits, l_bits, v_bits, f_bits;

    for (genvar j = 0; j < P_MAX_WIDTH; j++) begin : g_cell
        logic left_m, left_l, right_m, right_l, right_f;

        if (j == 0) begin : g_left_edge
            assign left_m = 1'b0;
            assign left_l = 1'b0;
        end else begin : g_left
            assign left_m = m_bits[j-1];
            assign left_l = l_bits[j-1];
        end

        if (j == P_MAX_WIDTH - 1) begin : g_right_edge
            assign right_m = 1'b0;
            assign right_l = 1'b0;
            assign right_f = 1'b0;
        end else begin : g_right
            assign right_m = m_bits[j+1];
            assign right_l = l_bits[j+1];
            assign right_f = f_bits[j+1];
        end

        bdc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_hit      (r_col == CW'(j)),
            .i_in_frame (WC'(j) < w_eff),
            .i_right_in (WC'(j + 1) < w_eff),
            .i_left_in  (WC'(j) <= w_eff),
            .i_left_m   (left_m),
            .i_right_m  (right_m),
            .i_left_l   (left_l),
            .i_right_l  (right_l),
            .i_right_f  (right_f),
            .o_m        (m_bits[j]),
            .o_l        (l_bits[j]),
            .o_v        (v_bits[j]),
            .o_f        (f_bits[j])
        );
    end

    // ---------------- output register ----------------
    logic                          r_out_valid, n_out_valid;
    logic                          r_dil, n_dil;
    logic [bdc_pkg::OUT_ROW_W-1:0] r_orow, n_orow;
    logic [bdc_pkg::OUT_COL_W-1:0] r_ocol, n_ocol;
    logic                          r_last, n_last;
    logic                          r_eof, n_eof;
    logic [31:0]                   row_m1, col_ext, frow_ext, fcol_ext;

    assign row_m1   = 32'(r_row) - 32'd1;
    assign col_ext  = 32'(r_col);
    assign frow_ext = 32'(r_frow);
    assign fcol_ext = 32'(r_fcol);

    always_comb begin
        n_out_valid = r_out_valid;
        n_dil       = r_dil;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        n_last      = r_last;
        n_eof       = r_eof;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept && (r_row != '0)) begin
            // row r-1 result; last of the run unless a flush follows
            n_out_valid = 1'b1;
            n_dil       = v_bits[r_col];
            n_orow      = row_m1[bdc_pkg::OUT_ROW_W-1:0];
            n_ocol      = col_ext[bdc_pkg::OUT_COL_W-1:0];
            n_last      = !frame_end;
            n_eof       = 1'b0;
        end else if (flush_load) begin
            n_out_valid = 1'b1;
            n_dil       = f_bits[0];
            n_orow      = frow_ext[bdc_pkg::OUT_ROW_W-1:0];
            n_ocol      = fcol_ext[bdc_pkg::OUT_COL_W-1:0];
            n_last      = flush_last;
            n_eof       = flush_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_dil  <= n_dil;
        r_orow <= n_orow;
        r_ocol <= n_ocol;
        r_last <= n_last;
        r_eof  <= n_eof;
    end

    assign o_out_valid     = r_out_valid;
    assign o_dilated_pixel = r_dil;
    assign o_out_row       = r_orow;
    assign o_out_col       = r_ocol;
    assign o_last_of_run   = r_last;
    assign o_end_of_frame  = r_eof;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for binary_dilation_cross (3x3 cross binary dilation).
// Depends on bdc_pkg and the binary_dilation_cross RTL; holds its own
// prediction of the dilated stream and checks every result transfer.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW           = bdc_pkg::MAX_WIDTH_DEF;
    localparam int MAXH           = bdc_pkg::MAX_HEIGHT_DEF;
    localparam int ROW_W          = bdc_pkg::OUT_ROW_W;
    localparam int COL_W          = bdc_pkg::OUT_COL_W;
    localparam int DATA_W         = bdc_pkg::CFG_DATA_W;
    localparam int RANDOM_PIXELS  = 80;
    // Settle time before a register write or the end of the run: the flush
    // walks at most MAXW cells plus the output register.
    localparam int SETTLE_CYCLES  = MAXW + 16;
    // Longest quiet stretch in a correct run is a drawn stall or gap, a
    // flush and a settle pause; this allows many times that.
    localparam int WATCHDOG_LIMIT = 4000;

    // One expected output pixel, field for field as the result port shows it.
    typedef struct packed {
        logic             dilated;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_run;
        logic             frame_end;
    } t_dilated_px;

    // One input pixel waiting for the driver, with its idle cycles ahead of it.
    typedef struct {
        logic value;
        int   gap;
    } t_pixel_item;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [bdc_pkg::CFG_INDEX_W-1:0] i_cfg_index = bdc_pkg::REG_FRAME_WIDTH;
    logic [DATA_W-1:0]               i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic                            i_pixel_in  = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic                            o_dilated_pixel;
    logic [ROW_W-1:0]                o_out_row;
    logic [COL_W-1:0]                o_out_col;
    logic                            o_last_of_run;
    logic                            o_end_of_frame;

    binary_dilation_cross i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_in      (i_pixel_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_dilated_pixel (o_dilated_pixel),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_frame  (o_end_of_frame)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies (reset values) and the three row
    // stores plus the position of the next pixel in the frame.
    // ------------------------------------------------------------------
    logic [bdc_pkg::FRAME_WIDTH_W-1:0]  reg_width  = bdc_pkg::FRAME_WIDTH_RST;
    logic [bdc_pkg::FRAME_HEIGHT_W-1:0] reg_height = bdc_pkg::FRAME_HEIGHT_RST;
    logic [MAXW-1:0]                    row_above  = '0;
    logic [MAXW-1:0]                    row_center = '0;
    logic [MAXW-1:0]                    row_below  = '0;   // row being filled
    int                                 col_pos    = 0;
    int                                 row_pos    = 0;

    t_dilated_px dilated_due[$];   // predicted results not yet seen
    t_pixel_item pixel_q[$];       // stimulus not yet presented

    // Scoreboard and run statistics
    int n_errors   = 0;
    int n_pixels   = 0;
    int n_results  = 0;
    int n_frames   = 0;
    int n_writes   = 0;
    bit pixel_held = 1'b0;   // an item sits on the input port
    bit in_calm    = 1'b0;   // sender runs back to back
    bit out_calm   = 1'b0;   // receiver never stalls

    // Out-of-range sizes clamp: 0 acts as 1, anything above the max as the max.
    function automatic int active_width();
        if (reg_width == 0) return 1;
        if (reg_width > MAXW) return MAXW;
        return int'(reg_width);
    endfunction

    function automatic int active_height();
        if (reg_height == 0) return 1;
        if (reg_height > MAXH) return MAXH;
        return int'(reg_height);
    endfunction

    // Columns at or past the frame width read as background.
    function automatic logic row_bit(logic [MAXW-1:0] r, int c, int w);
        if (c >= w) return 1'b0;
        return r[c];
    endfunction

    function automatic logic cross_at(logic [MAXW-1:0] up, logic [MAXW-1:0] mid,
                                      logic [MAXW-1:0] dn, int c, int w);
        logic v;
        v = row_bit(mid, c, w) | row_bit(up, c, w) | row_bit(dn, c, w)
          | row_bit(mid, c + 1, w);
        if (c > 0) v = v | row_bit(mid, c - 1, w);
        return v;
    endfunction

    // Advance the prediction by one accepted pixel and queue the output
    // pixels it releases: the pixel above it, and on the frame's last pixel
    // also the whole final row (its lower neighbours are outside the frame).
    function automatic void dilate_pixel(logic pix);
        int          w;
        int          h;
        int          col;
        logic        row_end;
        logic        frame_end;
        t_dilated_px px;
        t_dilated_px run[$];

        w         = active_width();
        h         = active_height();
        col       = col_pos;
        row_end   = (col >= w - 1);
        frame_end = row_end && (row_pos >= h - 1);
        row_below[col] = pix;

        if (row_pos >= 1) begin
            px.dilated   = cross_at(row_above, row_center, row_below, col, w);
            px.row       = ROW_W'(row_pos - 1);
            px.col       = COL_W'(col);
            px.last_run  = 1'b0;
            px.frame_end = 1'b0;
            run.push_back(px);
        end

        if (frame_end) begin
            for (int c = 0; c < w; c++) begin
                px.dilated   = cross_at(row_center, row_below, '0, c, w);
                px.row       = ROW_W'(row_pos);
                px.col       = COL_W'(c);
                px.last_run  = 1'b0;
                px.frame_end = (c == w - 1);
                run.push_back(px);
            end
            row_above  = '0;
            row_center = '0;
            row_below  = '0;
            col_pos    = 0;
            row_pos    = 0;
        end else if (row_end) begin
            row_above  = row_center;
            row_center = row_below;
            row_below  = '0;
            col_pos    = 0;
            row_pos++;
        end else begin
            col_pos = col + 1;
        end

        if (run.size() != 0) run[run.size() - 1].last_run = 1'b1;
        foreach (run[k]) dilated_due.push_back(run[k]);
    endfunction

    // Pixels still needed to close the current frame under the current sizes.
    function automatic int pixels_left_in_frame();
        int w;
        int h;
        int rest_of_row;
        int rows_after;

        w           = active_width();
        h           = active_height();
        rest_of_row = (col_pos >= w - 1) ? 1 : w - col_pos;
        rows_after  = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
        return rest_of_row + rows_after * w;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: presents queued items after their idle gap and feeds
    // the predictor at each input transfer. One NBA per signal per edge.
    // ------------------------------------------------------------------
    int          gap_count = 0;
    logic        drv_valid;
    logic        drv_pixel;
    t_pixel_item drv_item;

    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_pixel_in <= 1'b0;
            gap_count  = 0;
            pixel_held = 1'b0;
        end else begin
            drv_valid = i_in_valid;
            drv_pixel = i_pixel_in;
            if (i_in_valid && o_in_ready) begin
                dilate_pixel(i_pixel_in);
                n_pixels++;
                drv_valid  = 1'b0;
                pixel_held = 1'b0;
            end
            if (!drv_valid && pixel_q.size() != 0) begin
                if (gap_count >= pixel_q[0].gap) begin
                    drv_item   = pixel_q.pop_front();
                    drv_valid  = 1'b1;
                    drv_pixel  = drv_item.value;
                    pixel_held = 1'b1;
                    gap_count  = 0;
                end else begin
                    gap_count++;
                end
            end
            i_in_valid <= drv_valid;
            i_pixel_in <= drv_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each result transfer against the oldest
    // prediction, then holds ready low for a freshly drawn stall.
    // ------------------------------------------------------------------
    int          ready_wait = 0;
    int          stall_len;
    t_dilated_px seen;

    always @(posedge i_clk) begin : result_monitor
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_wait  = 0;
        end else if (o_out_valid && i_out_ready) begin
            n_results++;
            if (o_end_of_frame) n_frames++;
            if (dilated_due.size() == 0) begin
                $error("unexpected result: row %0d col %0d pixel %0d",
                       o_out_row, o_out_col, o_dilated_pixel);
                n_errors++;
            end else begin
                seen = dilated_due.pop_front();
                if (o_dilated_pixel !== seen.dilated) begin
                    $error("dilated_pixel: expected %0d, got %0d", seen.dilated,
                           o_dilated_pixel);
                    n_errors++;
                end
                if (o_out_row !== seen.row) begin
                    $error("out_row: expected %0d, got %0d", seen.row, o_out_row);
                    n_errors++;
                end
                if (o_out_col !== seen.col) begin
                    $error("out_col: expected %0d, got %0d", seen.col, o_out_col);
                    n_errors++;
                end
                if (o_last_of_run !== seen.last_run) begin
                    $error("last_of_run: expected %0d, got %0d", seen.last_run,
                           o_last_of_run);
                    n_errors++;
                end
                if (o_end_of_frame !== seen.frame_end) begin
                    $error("end_of_frame: expected %0d, got %0d", seen.frame_end,
                           o_end_of_frame);
                    n_errors++;
                end
            end
            stall_len   = out_calm ? 0 : $urandom_range(0, 17);
            ready_wait  = stall_len;
            i_out_ready <= (stall_len == 0);
        end else if (!i_out_ready) begin
            if (ready_wait <= 1) begin
                i_out_ready <= 1'b1;
                ready_wait  = 0;
            end else begin
                ready_wait--;
            end
        end
    end

    // Watchdog: any transfer restarts the count of quiet cycles.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Register write; the predictor copy follows once the write edge is past.
    task automatic write_reg(input logic [bdc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bdc_pkg::REG_FRAME_WIDTH) reg_width = val[bdc_pkg::FRAME_WIDTH_W-1:0];
        else reg_height = val;
        n_writes++;
    endtask

    // Fixed pixel pattern, bit k is the k-th pixel sent.
    task automatic queue_pattern(input logic [63:0] bits, input int count);
        t_pixel_item it;
        for (int k = 0; k < count; k++) begin
            it.value = bits[k];
            it.gap   = in_calm ? 0 : $urandom_range(0, 17);
            pixel_q.push_back(it);
        end
    endtask

    // Random pixels; density is the chance of a set pixel in eighths.
    task automatic queue_random(input int count, input int density);
        t_pixel_item it;
        for (int k = 0; k < count; k++) begin
            it.value = ($urandom_range(0, 7) < density);
            it.gap   = in_calm ? 0 : $urandom_range(0, 17);
            pixel_q.push_back(it);
        end
    endtask

    // Hold the sender until every predicted result has been seen, then let
    // a trailing flush or a result-free pixel settle inside the block.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || pixel_held || dilated_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int                n_random;
    int                sel;
    int                count;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] hdata;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame with set pixels in two opposite corners: dilation must
        // stop at every border.
        in_calm = 1'b1;
        write_reg(bdc_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(bdc_pkg::REG_FRAME_HEIGHT, 11'd3);
        queue_pattern(64'b100_000_001, 9);
        wait_idle();

        // Lone center pixel grows into a full plus, under random gaps.
        in_calm = 1'b0;
        queue_pattern(64'b000_010_000, 9);
        wait_idle();

        // Zero sizes act as a 1x1 frame: each pixel is a frame of its own.
        write_reg(bdc_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(bdc_pkg::REG_FRAME_HEIGHT, 11'd0);
        queue_pattern(64'b01, 2);
        wait_idle();

        // Oversized values clamp to the maxima (upper data bits beyond the
        // width register are dropped). Start a frame, then shrink the
        // sizes mid-frame: the current row and then the frame end early.
        write_reg(bdc_pkg::REG_FRAME_WIDTH, 11'h7FF);
        write_reg(bdc_pkg::REG_FRAME_HEIGHT, 11'h7FF);
        queue_pattern(64'b011, 3);
        wait_idle();
        write_reg(bdc_pkg::REG_FRAME_WIDTH, 11'd2);
        queue_pattern(64'b10, 2);
        wait_idle();
        write_reg(bdc_pkg::REG_FRAME_HEIGHT, 11'd1);
        queue_pattern(64'b01, 2);
        wait_idle();

        // Random phases: mostly whole frames from the current position,
        // sometimes a broken-off piece that the next phase's sizes finish.
        n_random = 0;
        while (n_random < RANDOM_PIXELS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       wdata = 11'd0;
                1:       wdata = 11'd32;
                2:       wdata = DATA_W'($urandom_range(33, 63)
                                 | ($urandom_range(0, 31) << bdc_pkg::FRAME_WIDTH_W));
                default: wdata = DATA_W'($urandom_range(1, 6));
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0:       hdata = 11'd0;
                1:       hdata = DATA_W'($urandom_range(MAXH + 1, 2047));
                default: hdata = DATA_W'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(bdc_pkg::REG_FRAME_WIDTH, wdata);
            if ($urandom_range(0, 3) != 0) write_reg(bdc_pkg::REG_FRAME_HEIGHT, hdata);

            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            count    = pixels_left_in_frame();
            if (count > 64) count = $urandom_range(1, 2 * active_width());
            else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);

            sel = $urandom_range(0, 2);
            queue_random(count, (sel == 0) ? 1 : (sel == 1) ? 4 : 7);
            n_random += count;
            wait_idle();
        end

        // wait_idle has already drained everything and waited out the block.
        $display("covered %0d pixels in, %0d result pixels checked, %0d frames closed,",
                 n_pixels, n_results, n_frames);
        $display("%0d register writes including clamped and mid-frame sizes", n_writes);
        if (n_errors == 0 && dilated_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
